// ===== rtl/assert_macros.svh =====
// Assertion macros for the job selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPJS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpjs: same-cycle check failed");
`define DPJS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpjs: next-cycle check failed");
`else
`define DPJS_ASSERT_IMPLY(lbl, ante, cons)
`define DPJS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/dpjs_pkg.sv =====
// Shared types and constants of the deadline/profit job selector.
`timescale 1ns / 1ps
package dpjs_pkg;

  localparam int TOTAL_W = 26;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Job classification codes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_ADD   = 3'd1;
  localparam logic [2:0] CLS_FULL  = 3'd2;
  localparam logic [2:0] CLS_REPL  = 3'd3;
  localparam logic [2:0] CLS_ORDER = 3'd4;

  typedef struct packed {
    logic [15:0] profit;
    logic [15:0] deadline;
    logic        last_job;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_profit;
    logic [10:0]        selected_count;
    logic               order_error;
    logic               overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic ins;
    logic rep;
    logic set_ovf;
    logic set_ord;
    logic rd_parent;
    logic rd_left;
    logic rd_right;
    logic hold_left;
    logic up_move;
    logic dn_move;
    logic place;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cls;
    logic       at_root;
    logic       has_left;
    logic       up_less;
    logic       dn_swap;
    logic       last;
    logic       out_busy;
  } sts_t;

endpackage

// ===== rtl/dpjs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dpjs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dpjs_ctrl.sv =====
// Sequencer for job classification and heap sift up / sift down.
`timescale 1ns / 1ps
module dpjs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpjs_pkg::sts_t sts,
  output dpjs_pkg::cmd_t cmd
);
  import dpjs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_UP_RD  = 3'd2;
  localparam logic [2:0] S_UP_CMP = 3'd3;
  localparam logic [2:0] S_DN_RDL = 3'd4;
  localparam logic [2:0] S_DN_RDR = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.cls)
          CLS_ADD: begin
            cmd.ins   = 1'b1;
            state_nxt = S_UP_RD;
          end
          CLS_REPL: begin
            cmd.rep   = 1'b1;
            state_nxt = S_DN_RDL;
          end
          CLS_FULL: begin
            cmd.set_ovf = 1'b1;
            state_nxt   = S_FIN;
          end
          CLS_ORDER: begin
            cmd.set_ord = 1'b1;
            state_nxt   = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_UP_RD: begin
        if (sts.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_RDL: begin
        if (!sts.has_left) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd.rd_right  = 1'b1;
        cmd.hold_left = 1'b1;
        state_nxt     = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_swap) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RDL;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Wait for a free result slot on the last job of a batch
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/dpjs_dp.sv =====
// Datapath: heap RAM, hole position, count, running total, flags and result register.
`timescale 1ns / 1ps
module dpjs_dp #(
  parameter int CAPACITY    = 1024,
  parameter int PROFIT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dpjs_pkg::cmd_t      cmd,
  output dpjs_pkg::sts_t      sts,
  input  dpjs_pkg::in_item_t  in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output dpjs_pkg::out_item_t out_item
);
  import dpjs_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = AW + 2;
  localparam int CMPW = (CW > 16) ? CW : 16;

  logic [PROFIT_BITS-1:0] prof_r;
  logic [15:0]            dl_r;
  logic                   last_r;
  logic [CW-1:0]          count_r;
  logic [TOTAL_W-1:0]     total_r;
  logic                   ord_r;
  logic                   ovf_r;
  logic [AW-1:0]          pos_r;
  logic [PROFIT_BITS-1:0] left_val_r;
  logic [PROFIT_BITS-1:0] root_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [31:0]            prof32;
  logic [CMPW-1:0]        dl_x;
  logic [CMPW-1:0]        cnt_x;
  logic [2:0]             cls;
  logic [IW-1:0]          left_i;
  logic [IW-1:0]          right_i;
  logic [IW-1:0]          cnt_i;
  logic [AW-1:0]          parent;
  logic                   has_left;
  logic                   has_right;
  logic [PROFIT_BITS-1:0] rdata;
  logic [PROFIT_BITS-1:0] min1;
  logic                   sel_l;
  logic                   sel_r;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [PROFIT_BITS-1:0] wdata;
  logic [32:0]            sum;
  logic [TOTAL_W-1:0]     total_nxt;
  logic [31:0]            cnt32;

  assign prof32 = 32'(in_item.profit);

  // Classify the held job against the count and the heap minimum
  assign dl_x  = CMPW'(dl_r);
  assign cnt_x = CMPW'(count_r);
  always_comb begin
    if (dl_r == 16'd0) begin
      cls = CLS_NONE;
    end else if (dl_x > cnt_x) begin
      cls = (count_r >= CW'(CAPACITY)) ? CLS_FULL : CLS_ADD;
    end else if (dl_x == cnt_x) begin
      cls = ((count_r != '0) && (prof_r > root_r)) ? CLS_REPL : CLS_NONE;
    end else begin
      cls = CLS_ORDER;
    end
  end

  // Heap index arithmetic
  assign left_i    = {1'b0, pos_r, 1'b1};
  assign right_i   = left_i + IW'(1);
  assign cnt_i     = IW'(count_r);
  assign parent    = (pos_r - AW'(1)) >> 1;
  assign has_left  = left_i < cnt_i;
  assign has_right = right_i < cnt_i;

  // Sift-down pick: strict less, left before right
  assign sel_l = left_val_r < prof_r;
  assign min1  = sel_l ? left_val_r : prof_r;
  assign sel_r = has_right && (rdata < min1);

  always_comb begin
    if (cmd.rd_left) begin
      raddr = left_i[AW-1:0];
    end else if (cmd.rd_right) begin
      raddr = has_right ? right_i[AW-1:0] : left_i[AW-1:0];
    end else begin
      raddr = parent;
    end
  end

  // Move a parent or child into the hole, or drop the held profit there
  assign we = cmd.place | cmd.up_move | cmd.dn_move;
  always_comb begin
    if (cmd.place) begin
      wdata = prof_r;
    end else if (cmd.up_move) begin
      wdata = rdata;
    end else begin
      wdata = sel_r ? rdata : left_val_r;
    end
  end

  dpjs_ram #(
    .WIDTH (PROFIT_BITS),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (pos_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Saturating total update; replacement backs out the old minimum
  assign sum = 33'(total_r) - (cmd.rep ? 33'(root_r) : 33'd0) + 33'(prof_r);
  always_comb begin
    if (total_r == TOTAL_MAX) begin
      total_nxt = total_r;
    end else if (sum > 33'(TOTAL_MAX)) begin
      total_nxt = TOTAL_MAX;
    end else begin
      total_nxt = sum[TOTAL_W-1:0];
    end
  end

  assign cnt32 = 32'(count_r);

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prof_r <= prof32[PROFIT_BITS-1:0];
      dl_r   <= in_item.deadline;
      last_r <= in_item.last_job;
    end
    if (cmd.hold_left) begin
      left_val_r <= rdata;
    end
    if (we && (pos_r == '0)) begin
      root_r <= wdata;
    end
    if (cmd.ins) begin
      pos_r <= count_r[AW-1:0];
    end else if (cmd.rep) begin
      pos_r <= '0;
    end else if (cmd.up_move) begin
      pos_r <= parent;
    end else if (cmd.dn_move) begin
      pos_r <= sel_r ? right_i[AW-1:0] : left_i[AW-1:0];
    end
    if (cmd.emit) begin
      out_item_r.total_profit   <= total_r;
      out_item_r.selected_count <= cnt32[10:0];
      out_item_r.order_error    <= ord_r;
      out_item_r.overflow       <= ovf_r;
    end
  end

  // Batch state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      ord_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count_r <= '0;
        total_r <= '0;
        ord_r   <= 1'b0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.ins) begin
          count_r <= count_r + CW'(1);
        end
        if (cmd.ins || cmd.rep) begin
          total_r <= total_nxt;
        end
        if (cmd.set_ord) begin
          ord_r <= 1'b1;
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.cls      = cls;
  assign sts.at_root  = (pos_r == '0);
  assign sts.has_left = has_left;
  assign sts.up_less  = prof_r < rdata;
  assign sts.dn_swap  = sel_l | sel_r;
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/deadline_profit_job_selector.sv =====
// Top level of the deadline/profit job selector.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Greedy job selector: jobs arrive sorted by nondecreasing deadline and the
// chosen profits are kept in a min-heap held in one single-port-read RAM of
// CAPACITY entries. One job is worked at a time. A dropped, ignored or
// flagged job goes straight to the finish state. An insertion sifts up until
// it climbs to the root or a compare stops it. A replacement of the minimum
// sifts down from the root until it reaches a node without children or a
// compare stops it. The cost per level is set by the RAM's one registered
// read port: sift-up reads the parent, and sift-down reads the left and
// then the right child. The job flagged last_job yields one result item
// with the total, count and error flags, after which the batch state
// clears. That job completes only once the result register is free. No
// clearing pass is needed after reset.
module deadline_profit_job_selector #(
  parameter int CAPACITY    = 1024,
  parameter int PROFIT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dpjs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dpjs_pkg::out_item_t out_item
);
  import dpjs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dpjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpjs_dp #(
    .CAPACITY    (CAPACITY),
    .PROFIT_BITS (PROFIT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Only one source writes the heap RAM in a cycle
  `DPJS_ASSERT_IMPLY(a_one_write, 1'b1, $onehot0({cmd.place, cmd.up_move, cmd.dn_move}))
  // A result never overwrites one that is still waiting
  `DPJS_ASSERT_IMPLY(a_emit_free, cmd.emit, !(out_valid && !out_ready))
  // One job in flight: no accept right after an accept
  `DPJS_ASSERT_NEXT(a_one_job, in_valid && in_ready, !in_ready)
  // Sift-up never reads above the root
  `DPJS_ASSERT_IMPLY(a_up_root, cmd.rd_parent, !sts.at_root)

endmodule

// ===== tb/sv/deadline_profit_job_selector_test.sv =====
// Self-checking testbench for the deadline/profit job selector.
`timescale 1ns / 1ps
module deadline_profit_job_selector_test;
  import dpjs_pkg::*;

  localparam int HEAP_SLOTS  = 1024;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_OFF    = 300;
  localparam int DRAIN_WAIT  = 60;
  localparam int RANDOM_JOBS = 1350;
  localparam int MIN_BATCHES = 30;
  localparam out_item_t NO_RES = '0;

  typedef struct {
    in_item_t  job;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Model of the selection state
  logic [15:0]     chosen_heap [HEAP_SLOTS];
  int unsigned     chosen_count;
  longint unsigned profit_sum;
  bit              order_seen;
  bit              overflow_seen;

  out_item_t results_due[$];
  out_item_t want;
  int        mismatches;
  int        jobs_sent;
  int        idle_cycles;
  bit        calm;

  // Directed jobs; typed results are those readable by hand
  plan_row_t plan [23] = '{
    // deadline zero on a last job after reset: empty result
    '{'{16'hFFFF, 16'd0, 1'b1}, 1'b1, '{26'd0, 11'd0, 1'b0, 1'b0}},
    // add, tie ignored, replacement, add, out-of-order, dropped last
    '{'{16'd5, 16'd1, 1'b0}, 1'b0, NO_RES},
    '{'{16'd5, 16'd1, 1'b0}, 1'b0, NO_RES},
    '{'{16'd9, 16'd1, 1'b0}, 1'b0, NO_RES},
    '{'{16'd3, 16'd2, 1'b0}, 1'b0, NO_RES},
    '{'{16'd7, 16'd1, 1'b0}, 1'b0, NO_RES},
    '{'{16'd0, 16'd0, 1'b1}, 1'b1, '{26'd12, 11'd2, 1'b1, 1'b0}},
    // field extremes
    '{'{16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'h0000, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'h0001, 16'hFFFF, 1'b1}, 1'b1, '{26'd65536, 11'd3, 1'b0, 1'b0}},
    // replacement with only a left child under the root
    '{'{16'd4, 16'd1, 1'b0}, 1'b0, NO_RES},
    '{'{16'd6, 16'd2, 1'b0}, 1'b0, NO_RES},
    '{'{16'd10, 16'd2, 1'b0}, 1'b0, NO_RES},
    '{'{16'd8, 16'd2, 1'b0}, 1'b0, NO_RES},
    '{'{16'd7, 16'd2, 1'b1}, 1'b0, NO_RES},
    // deep sift-up, then a deep sift-down, then sift-up to the root
    '{'{16'd50, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd40, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd30, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd20, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd10, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd5, 16'hFFFF, 1'b0}, 1'b0, NO_RES},
    '{'{16'd60, 16'd6, 1'b0}, 1'b0, NO_RES},
    '{'{16'd1, 16'd7, 1'b1}, 1'b0, NO_RES}
  };

  deadline_profit_job_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturating add into the running profit sum
  function automatic void add_profit(input logic [15:0] value);
    if (profit_sum >= TOTAL_MAX) return;
    profit_sum += value;
    if (profit_sum > TOTAL_MAX) profit_sum = TOTAL_MAX;
  endfunction

  // Apply one job to the selection state; returns 1 when a result is due
  function automatic bit select_job(input in_item_t job, output out_item_t res);
    int unsigned pos;
    int unsigned parent;
    int unsigned left;
    int unsigned pick;
    logic [15:0] tmp;
    bit          moving;
    res = '0;
    if (job.deadline == 16'd0) begin
      // drop silently
    end else if (job.deadline > chosen_count) begin
      if (chosen_count >= HEAP_SLOTS) begin
        overflow_seen = 1'b1;
      end else begin
        chosen_heap[chosen_count] = job.profit;
        pos = chosen_count;
        chosen_count++;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (chosen_heap[pos] < chosen_heap[parent]) begin
            tmp = chosen_heap[pos];
            chosen_heap[pos] = chosen_heap[parent];
            chosen_heap[parent] = tmp;
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
        add_profit(job.profit);
      end
    end else if (job.deadline == chosen_count) begin
      if (chosen_count > 0 && job.profit > chosen_heap[0]) begin
        if (profit_sum < TOTAL_MAX) begin
          profit_sum -= chosen_heap[0];
          add_profit(job.profit);
        end
        chosen_heap[0] = job.profit;
        pos = 0;
        moving = 1'b1;
        // both children bounded by the live count
        while (moving && pos * 2 + 1 < chosen_count) begin
          left = pos * 2 + 1;
          pick = pos;
          if (chosen_heap[left] < chosen_heap[pick]) pick = left;
          if (left + 1 < chosen_count && chosen_heap[left + 1] < chosen_heap[pick])
            pick = left + 1;
          if (pick == pos) begin
            moving = 1'b0;
          end else begin
            tmp = chosen_heap[pos];
            chosen_heap[pos] = chosen_heap[pick];
            chosen_heap[pick] = tmp;
            pos = pick;
          end
        end
      end
    end else begin
      order_seen = 1'b1;
    end

    if (!job.last_job) return 1'b0;
    res.total_profit   = profit_sum[TOTAL_W-1:0];
    res.selected_count = chosen_count[10:0];
    res.order_error    = order_seen;
    res.overflow       = overflow_seen;
    chosen_count  = 0;
    profit_sum    = 0;
    order_seen    = 1'b0;
    overflow_seen = 1'b0;
    return 1'b1;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until accepted, then record its result
  task automatic send_job(input in_item_t job, input bit typed, input out_item_t typed_res);
    int        gap;
    out_item_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = job;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    jobs_sent++;
    if (select_job(job, res)) results_due.push_back(typed ? typed_res : res);
  endtask

  // Stimulus
  initial begin
    int        batches;
    int        batch_len;
    int        r;
    logic [15:0] dl;
    in_item_t  job;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    mismatches    = 0;
    jobs_sent     = 0;
    calm          = 1'b0;
    chosen_count  = 0;
    profit_sum    = 0;
    order_seen    = 1'b0;
    overflow_seen = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_job(plan[i].job, plan[i].typed, plan[i].res);

    jobs_sent = 0;
    batches   = 0;
    while (jobs_sent < RANDOM_JOBS || batches < MIN_BATCHES) begin
      calm = ($urandom_range(0, 4) == 0);
      if (batches == 3) begin
        // fill the heap, then alternate replacements and overflow drops
        for (int k = 0; k < HEAP_SLOTS + 12; k++) begin
          job.profit = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(16'hC000, 16'hFFFF));
          if (k >= HEAP_SLOTS && k[0])
            job.deadline = 16'(HEAP_SLOTS);
          else
            job.deadline = 16'($urandom_range(HEAP_SLOTS + 1, 65535));
          job.last_job = (k == HEAP_SLOTS + 11);
          send_job(job, 1'b0, NO_RES);
        end
      end else begin
        // mostly sorted deadlines near the count, with some noise
        batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
        dl = 16'($urandom_range(1, 2));
        for (int k = 0; k < batch_len; k++) begin
          r = $urandom_range(0, 99);
          job.profit = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7))
                                                   : 16'($urandom_range(0, 65535));
          if (r < 6) begin
            job.deadline = 16'd0;
          end else if (r < 12) begin
            job.deadline = 16'($urandom_range(0, 65535));
          end else begin
            dl += (r >= 97) ? 16'($urandom_range(2, 20)) : 16'($urandom_range(0, 1));
            job.deadline = dl;
          end
          job.last_job = (k == batch_len - 1) || (r == 50);
          send_job(job, 1'b0, NO_RES);
        end
      end
      batches++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver: long hold-off first so the block backs up, then random stalls
  initial begin
    int stall_left;
    int r;
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    repeat (HOLD_OFF) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!calm && r >= 70) stall_left = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result with none expected: total_profit %0d selected_count %0d",
                 out_item.total_profit, out_item.selected_count);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_item.total_profit !== want.total_profit) begin
            $error("total_profit: expected %0d, got %0d", want.total_profit,
                   out_item.total_profit);
            mismatches++;
          end
          if (out_item.selected_count !== want.selected_count) begin
            $error("selected_count: expected %0d, got %0d", want.selected_count,
                   out_item.selected_count);
            mismatches++;
          end
          if (out_item.order_error !== want.order_error) begin
            $error("order_error: expected %0b, got %0b", want.order_error,
                   out_item.order_error);
            mismatches++;
          end
          if (out_item.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_item.overflow);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no item moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
